@@ hw/rtl/qpps_pkg.sv @@
// ----------------------------------------------------------------------------
// qpps_pkg
// Shared constants, codes and arithmetic helpers for the quadrature position
// PID servo core.
// ----------------------------------------------------------------------------
package qpps_pkg;

    localparam int COUNT_W = 32;
    localparam int ACC_W   = 64;
    localparam int DUTY_W  = 10;
    localparam int FRAC_W  = 16;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // encoder counts per output-gear revolution, signed so the product stays signed
    localparam logic signed [16:0] COUNTS_PER_REV = 17'sd216;

    localparam logic [DUTY_W-1:0] DUTY_MAX_RESET = 10'd100;

    typedef enum logic [1:0] {
        ACT_EDGE_A = 2'd0,
        ACT_EDGE_B = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_TARGET = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_GAIN_NOW   = 2'd0,
        REG_GAIN_PREV  = 2'd1,
        REG_GAIN_PREV2 = 2'd2,
        REG_DUTY_MAX   = 2'd3
    } t_reg_index;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // signed add that clamps at the 64-bit limits
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W-1:0] sum;
        logic                    ovf;
        sum = a + b;
        ovf = (a[ACC_W-1] == b[ACC_W-1]) && (sum[ACC_W-1] != a[ACC_W-1]);
        if (ovf) begin
            return a[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end
        return sum;
    endfunction

endpackage

@@ hw/rtl/quadrature_position_pid_servo_core.sv @@
// ----------------------------------------------------------------------------
// quadrature_position_pid_servo_core
// Quadrature encoder counter with an incremental PID position loop.
// ----------------------------------------------------------------------------
// Every transfer on the input channel yields exactly one result, and a new item
// is taken every cycle while the output side is free. Encoder edges and target
// updates change the count and reference as they are taken; a control tick then
// runs through a product stage (three 32x32 multipliers in parallel) and an
// accumulate stage whose update of the 64-bit drive accumulator lets ticks follow
// each other back to back. A final stage turns the error sign and the accumulator
// into direction and clamped duty. Each stage holds its item when the next one is
// full, so bubbles fill while a result waits. The user must write gains and
// duty_max over the APB port only while the core is idle; the core itself does
// not enforce this. pready is always high.
module quadrature_position_pid_servo_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [1:0]                             i_action,
    input  logic                                   i_level_a,
    input  logic                                   i_level_b,
    input  logic signed [15:0]                     i_target_revs,

    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [qpps_pkg::COUNT_W-1:0]    o_position_count,
    output logic signed [qpps_pkg::COUNT_W-1:0]    o_error_count,
    output logic                                   o_drive_valid,
    output logic                                   o_drive_dir,
    output logic [qpps_pkg::DUTY_W-1:0]            o_duty,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [qpps_pkg::ADDR_W-1:0]            paddr,
    input  logic [qpps_pkg::DATA_W-1:0]            pwdata,
    output logic [qpps_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready
);

    localparam int CW = qpps_pkg::COUNT_W;
    localparam int AW = qpps_pkg::ACC_W;
    localparam int DW = qpps_pkg::DUTY_W;
    localparam int FW = qpps_pkg::FRAC_W;

    // configuration
    logic signed [CW-1:0] r_gain_now, r_gain_prev, r_gain_prev2;
    logic [DW-1:0]        r_duty_max;
    logic                 cfg_wr;
    logic [1:0]           cfg_idx;

    // loop state
    logic signed [CW-1:0] r_position, n_position;
    logic signed [CW-1:0] r_reference, n_reference;
    logic signed [CW-1:0] r_err_last, r_err_prev2;
    logic signed [AW-1:0] r_acc, n_acc;

    // stage valids and handshake
    logic r_v1, r_v2, r_v3, r_ov;
    logic rdy1, rdy2, rdy3;
    logic in_xfer, mv1, mv2;

    // stage payloads
    logic signed [CW-1:0] r_s1_pos, r_s1_err, n_err;
    logic                 r_s1_tick;
    logic signed [CW-1:0] r_s2_pos, r_s2_err;
    logic                 r_s2_tick;
    logic signed [AW-1:0] r_p_now, r_p_prev, r_p_prev2;
    logic signed [AW-1:0] n_p_now, n_p_prev, n_p_prev2;
    logic signed [CW-1:0] r_s3_pos, r_s3_err;
    logic                 r_s3_tick;
    logic signed [AW-1:0] r_s3_m;

    logic signed [CW-1:0] r_o_pos, r_o_err;
    logic                 r_o_drive_valid, r_o_dir;
    logic [DW-1:0]        r_o_duty, n_duty;

    logic signed [CW:0]   err_diff;
    logic signed [32:0]   ref_prod;
    logic signed [AW-1:0] drive_x, duty_top;
    logic                 s3_dir;

    // ------------------------------------------------------------------
    // APB configuration
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_now   <= '0;
            r_gain_prev  <= '0;
            r_gain_prev2 <= '0;
            r_duty_max   <= qpps_pkg::DUTY_MAX_RESET;
        end else if (cfg_wr) begin
            unique case (qpps_pkg::t_reg_index'(cfg_idx))
                qpps_pkg::REG_GAIN_NOW:   r_gain_now   <= pwdata;
                qpps_pkg::REG_GAIN_PREV:  r_gain_prev  <= pwdata;
                qpps_pkg::REG_GAIN_PREV2: r_gain_prev2 <= pwdata;
                qpps_pkg::REG_DUTY_MAX:   r_duty_max   <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (qpps_pkg::t_reg_index'(cfg_idx))
            qpps_pkg::REG_GAIN_NOW:   prdata = r_gain_now;
            qpps_pkg::REG_GAIN_PREV:  prdata = r_gain_prev;
            qpps_pkg::REG_GAIN_PREV2: prdata = r_gain_prev2;
            qpps_pkg::REG_DUTY_MAX:   prdata = {{(qpps_pkg::DATA_W-DW){1'b0}}, r_duty_max};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake: each stage advances when the next is empty or moving
    // ------------------------------------------------------------------
    assign rdy3    = !r_ov || i_ready;
    assign rdy2    = !r_v3 || rdy3;
    assign rdy1    = !r_v2 || rdy2;
    assign o_ready = !r_v1 || rdy1;
    assign in_xfer = i_valid && o_ready;
    assign mv1     = r_v1 && rdy1;
    assign mv2     = r_v2 && rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_ready) r_v1 <= i_valid;
            if (rdy1)    r_v2 <= r_v1;
            if (rdy2)    r_v3 <= r_v2;
            if (rdy3)    r_ov <= r_v3;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: count, reference and error
    // ------------------------------------------------------------------
    assign ref_prod = 33'(i_target_revs) * 33'(qpps_pkg::COUNTS_PER_REV);

    always_comb begin
        n_position  = r_position;
        n_reference = r_reference;
        case (qpps_pkg::t_action'(i_action))
            qpps_pkg::ACT_EDGE_A:
                n_position = (i_level_a != i_level_b) ? r_position + 1'b1
                                                      : r_position - 1'b1;
            qpps_pkg::ACT_EDGE_B:
                n_position = (i_level_a == i_level_b) ? r_position + 1'b1
                                                      : r_position - 1'b1;
            qpps_pkg::ACT_TARGET:
                n_reference = ref_prod[CW-1:0];
            default: ;
        endcase
        err_diff = (CW+1)'(n_reference) - (CW+1)'(n_position);
        if (err_diff[CW] != err_diff[CW-1]) begin
            n_err = err_diff[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            n_err = err_diff[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= '0;
            r_reference <= '0;
        end else if (in_xfer) begin
            r_position  <= n_position;
            r_reference <= n_reference;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_s1_pos  <= n_position;
            r_s1_err  <= n_err;
            r_s1_tick <= (i_action == qpps_pkg::ACT_TICK);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: PID products; shift the error history on a tick
    // ------------------------------------------------------------------
    assign n_p_now   = r_gain_now   * r_s1_err;
    assign n_p_prev  = r_gain_prev  * r_err_last;
    assign n_p_prev2 = r_gain_prev2 * r_err_prev2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_last  <= '0;
            r_err_prev2 <= '0;
        end else if (mv1 && r_s1_tick) begin
            r_err_prev2 <= r_err_last;
            r_err_last  <= r_s1_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s2_pos  <= r_s1_pos;
            r_s2_err  <= r_s1_err;
            r_s2_tick <= r_s1_tick;
            r_p_now   <= n_p_now;
            r_p_prev  <= n_p_prev;
            r_p_prev2 <= n_p_prev2;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: accumulate in order, saturating at each add
    // ------------------------------------------------------------------
    assign n_acc = qpps_pkg::sat_add(
                       qpps_pkg::sat_add(qpps_pkg::sat_add(r_acc, r_p_now), r_p_prev),
                       r_p_prev2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (mv2 && r_s2_tick) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s3_pos  <= r_s2_pos;
            r_s3_err  <= r_s2_err;
            r_s3_tick <= r_s2_tick;
            r_s3_m    <= n_acc;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: direction and clamped duty
    // ------------------------------------------------------------------
    assign s3_dir   = !r_s3_err[CW-1] && (r_s3_err != '0);
    assign duty_top = {{(AW-DW-FW){1'b0}}, r_duty_max, {FW{1'b0}}};

    always_comb begin
        if (s3_dir) begin
            drive_x = (r_s3_m == qpps_pkg::ACC_MIN) ? qpps_pkg::ACC_MAX : -r_s3_m;
        end else begin
            drive_x = r_s3_m;
        end
        if (drive_x[AW-1] || drive_x == '0) begin
            n_duty = '0;
        end else if (drive_x >= duty_top) begin
            n_duty = r_duty_max;
        end else begin
            n_duty = drive_x[FW+DW-1:FW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_o_pos         <= r_s3_pos;
            r_o_err         <= r_s3_err;
            r_o_drive_valid <= r_s3_tick;
            r_o_dir         <= r_s3_tick && s3_dir;
            r_o_duty        <= r_s3_tick ? n_duty : '0;
        end
    end

    assign o_valid          = r_ov;
    assign o_position_count = r_o_pos;
    assign o_error_count    = r_o_err;
    assign o_drive_valid    = r_o_drive_valid;
    assign o_drive_dir      = r_o_dir;
    assign o_duty           = r_o_duty;

endmodule

@@ hw/rtl/qpps_checker.sv @@
// ----------------------------------------------------------------------------
// qpps_checker
// Port-level checks for the quadrature position PID servo core.
// ----------------------------------------------------------------------------
module qpps_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic signed [qpps_pkg::COUNT_W-1:0] o_position_count,
    input  logic signed [qpps_pkg::COUNT_W-1:0] o_error_count,
    input  logic                                o_drive_valid,
    input  logic                                o_drive_dir,
    input  logic [qpps_pkg::DUTY_W-1:0]         o_duty,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qpps_pkg::ADDR_W-1:0]         paddr,
    input  logic [qpps_pkg::DATA_W-1:0]         pwdata,
    input  logic [qpps_pkg::DATA_W-1:0]         prdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_position_count)
            && $stable(o_error_count) && $stable(o_duty))
        else $error("result changed while stalled");

    a_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_drive_valid |-> !o_drive_dir && o_duty == '0)
        else $error("drive fields set on a non-tick result");

    a_dir_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drive_valid |-> o_drive_dir == (o_error_count > 0))
        else $error("drive direction disagrees with error sign");

    // a 32-bit gain reads back what was just written
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr[3:2] != qpps_pkg::REG_DUTY_MAX
            ##1 psel && !pwrite && paddr == $past(paddr)
            |-> prdata == $past(pwdata))
        else $error("register read-back mismatch");

endmodule

bind quadrature_position_pid_servo_core qpps_checker u_qpps_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_position_count (o_position_count),
    .o_error_count    (o_error_count),
    .o_drive_valid    (o_drive_valid),
    .o_drive_dir      (o_drive_dir),
    .o_duty           (o_duty),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata)
);

@@ dv/quadrature_position_pid_servo_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_position_pid_servo_core_tb
// Drives encoder edges, new targets and control ticks through the servo core
// under random backpressure and compares every result field against a
// cycle-free mirror of the count, the reference and the incremental PID law.
// ----------------------------------------------------------------------------
module quadrature_position_pid_servo_core_tb;

    localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_LO = 64'sh8000_0000_0000_0000;

    typedef struct {
        qpps_pkg::t_action  action;
        logic               level_a;
        logic               level_b;
        logic signed [15:0] target_revs;
    } t_servo_item;

    typedef struct {
        logic signed [qpps_pkg::COUNT_W-1:0] position_count;
        logic signed [qpps_pkg::COUNT_W-1:0] error_count;
        logic                                drive_valid;
        logic                                drive_dir;
        logic [qpps_pkg::DUTY_W-1:0]         duty;
    } t_servo_result;

    // mirror of the servo: count, reference, error history and drive accumulator
    class servo_shadow;
        logic signed [31:0]          gain_now_r;
        logic signed [31:0]          gain_prev_r;
        logic signed [31:0]          gain_prev2_r;
        logic [qpps_pkg::DUTY_W-1:0] duty_max_r;
        logic signed [31:0]          count_r;
        logic signed [31:0]          goal_r;
        longint                      err_1;
        longint                      err_2;
        longint                      acc_r;
        t_servo_result               due_results[$];
        int                          fails;

        function new();
            gain_now_r   = '0;
            gain_prev_r  = '0;
            gain_prev2_r = '0;
            duty_max_r   = qpps_pkg::DUTY_MAX_RESET;
            count_r      = '0;
            goal_r       = '0;
            err_1        = 0;
            err_2        = 0;
            acc_r        = 0;
            fails        = 0;
        endfunction

        function void set_reg(qpps_pkg::t_reg_index idx, logic [31:0] val);
            case (idx)
                qpps_pkg::REG_GAIN_NOW:   gain_now_r   = val;
                qpps_pkg::REG_GAIN_PREV:  gain_prev_r  = val;
                qpps_pkg::REG_GAIN_PREV2: gain_prev2_r = val;
                qpps_pkg::REG_DUTY_MAX:   duty_max_r   = val[qpps_pkg::DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_add(longint a, longint b);
            logic signed [64:0] wide;
            wide = 65'(a) + 65'(b);
            if (wide > 65'(ACC_HI)) return ACC_HI;
            if (wide < 65'(ACC_LO)) return ACC_LO;
            return longint'(wide[63:0]);
        endfunction

        function void log_item(t_servo_item it);
            longint        e;
            longint        m;
            longint        x;
            longint        top;
            t_servo_result r;
            case (it.action)
                qpps_pkg::ACT_EDGE_A:
                    count_r = (it.level_a != it.level_b) ? count_r + 32'sd1
                                                         : count_r - 32'sd1;
                qpps_pkg::ACT_EDGE_B:
                    count_r = (it.level_a == it.level_b) ? count_r + 32'sd1
                                                         : count_r - 32'sd1;
                qpps_pkg::ACT_TARGET:
                    goal_r = 32'(longint'(it.target_revs)
                                 * longint'(qpps_pkg::COUNTS_PER_REV));
                default: ;
            endcase
            e = longint'(goal_r) - longint'(count_r);
            if (e > 64'sd2147483647) e = 64'sd2147483647;
            if (e < -64'sd2147483648) e = -64'sd2147483648;
            r.position_count = count_r;
            r.error_count    = 32'(e);
            r.drive_valid    = 1'b0;
            r.drive_dir      = 1'b0;
            r.duty           = '0;
            if (it.action == qpps_pkg::ACT_TICK) begin
                m = clamp_add(acc_r, longint'(gain_now_r) * e);
                m = clamp_add(m, longint'(gain_prev_r) * err_1);
                m = clamp_add(m, longint'(gain_prev2_r) * err_2);
                err_2 = err_1;
                err_1 = e;
                acc_r = m;
                r.drive_valid = 1'b1;
                if (e > 0) begin
                    r.drive_dir = 1'b1;
                    x = (m == ACC_LO) ? ACC_HI : -m;
                end else begin
                    x = m;
                end
                top = longint'(duty_max_r) * 65536;
                if (x <= 0) begin
                    r.duty = '0;
                end else if (x >= top) begin
                    r.duty = duty_max_r;
                end else begin
                    r.duty = qpps_pkg::DUTY_W'(x >>> qpps_pkg::FRAC_W);
                end
            end
            due_results.push_back(r);
        endfunction

        function void compare_result(t_servo_result got);
            t_servo_result want;
            if (due_results.size() == 0) begin
                $error("unexpected result: position_count %0d error_count %0d",
                       got.position_count, got.error_count);
                fails++;
                return;
            end
            want = due_results.pop_front();
            if (got.position_count !== want.position_count) begin
                $error("position_count expected %0d actual %0d",
                       want.position_count, got.position_count);
                fails++;
            end
            if (got.error_count !== want.error_count) begin
                $error("error_count expected %0d actual %0d", want.error_count, got.error_count);
                fails++;
            end
            if (got.drive_valid !== want.drive_valid) begin
                $error("drive_valid expected %0d actual %0d", want.drive_valid, got.drive_valid);
                fails++;
            end
            if (got.drive_dir !== want.drive_dir) begin
                $error("drive_dir expected %0d actual %0d", want.drive_dir, got.drive_dir);
                fails++;
            end
            if (got.duty !== want.duty) begin
                $error("duty expected %0d actual %0d", want.duty, got.duty);
                fails++;
            end
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic [1:0]                          i_action = '0;
    logic                                i_level_a = 1'b0;
    logic                                i_level_b = 1'b0;
    logic signed [15:0]                  i_target_revs = '0;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic signed [qpps_pkg::COUNT_W-1:0] o_position_count;
    logic signed [qpps_pkg::COUNT_W-1:0] o_error_count;
    logic                                o_drive_valid;
    logic                                o_drive_dir;
    logic [qpps_pkg::DUTY_W-1:0]         o_duty;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [qpps_pkg::ADDR_W-1:0]         paddr = '0;
    logic [qpps_pkg::DATA_W-1:0]         pwdata = '0;
    logic [qpps_pkg::DATA_W-1:0]         prdata;
    logic                                pready;

    servo_shadow sb = new();
    int          send_idle = 0;
    int          recv_idle = 0;
    logic        qa = 1'b0;
    logic        qb = 1'b0;
    logic        run_up = 1'b1;

    quadrature_position_pid_servo_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_level_a        (i_level_a),
        .i_level_b        (i_level_b),
        .i_target_revs    (i_target_revs),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_position_count (o_position_count),
        .o_error_count    (o_error_count),
        .o_drive_valid    (o_drive_valid),
        .o_drive_dir      (o_drive_dir),
        .o_duty           (o_duty),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    // sample at the falling edge; the transfer completes at the next rising edge
    always @(negedge i_clk) begin
        t_servo_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.position_count = o_position_count;
            got.error_count    = o_error_count;
            got.drive_valid    = o_drive_valid;
            got.drive_dir      = o_drive_dir;
            got.duty           = o_duty;
            sb.compare_result(got);
        end
    end

    task automatic write_reg(qpps_pkg::t_reg_index idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send_item(qpps_pkg::t_action act, logic a, logic b,
                             logic signed [15:0] t);
        t_servo_item it;
        logic        seen;
        it.action      = act;
        it.level_a     = a;
        it.level_b     = b;
        it.target_revs = t;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_level_a     <= a;
        i_level_b     <= b;
        i_target_revs <= t;
        forever begin
            @(negedge i_clk);
            seen = o_ready;
            if (seen) sb.log_item(it);
            @(posedge i_clk);
            if (seen) break;
        end
    endtask

    task automatic send_random_item();
        int                 roll;
        logic signed [15:0] t;
        roll = $urandom_range(99);
        t    = 16'($urandom);
        if (roll < 55) begin
            // legal quadrature step along the current direction of travel
            if ($urandom_range(99) < 8) run_up = ~run_up;
            if (run_up == (qa == qb)) begin
                qa = ~qa;
                send_item(qpps_pkg::ACT_EDGE_A, qa, qb, t);
            end else begin
                qb = ~qb;
                send_item(qpps_pkg::ACT_EDGE_B, qa, qb, t);
            end
        end else if (roll < 65) begin
            send_item($urandom_range(1) ? qpps_pkg::ACT_EDGE_B : qpps_pkg::ACT_EDGE_A,
                      1'($urandom), 1'($urandom), t);
        end else if (roll < 85) begin
            send_item(qpps_pkg::ACT_TICK, 1'($urandom), 1'($urandom), t);
        end else begin
            case ($urandom_range(9))
                0:       t = 16'sh7FFF;
                1:       t = 16'sh8000;
                2, 3, 4: t = 16'(int'($urandom_range(8)) - 4);
                default: ;
            endcase
            send_item(qpps_pkg::ACT_TARGET, 1'($urandom), 1'($urandom), t);
        end
    endtask

    // wait until every transfer has come back, then let the pipeline settle
    task automatic drain();
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_phase(int p);
        logic [31:0] g0;
        logic [31:0] g1;
        logic [31:0] g2;
        logic [31:0] dm;
        g0 = $urandom;
        g1 = $urandom;
        g2 = $urandom;
        dm = $urandom_range(1, 1023);
        case (p)
            0: begin
                g0 = 32'hFFFD_0000;
                g1 = 32'h0004_8000;
                g2 = 32'hFFFF_8000;
                dm = 300;
            end
            1: begin
                g0 = 32'h7FFF_FFFF;
                g1 = 32'h7FFF_FFFF;
                g2 = 32'h7FFF_FFFF;
                dm = 1023;
            end
            2: begin
                g0 = 32'h8000_0000;
                g1 = 32'h8000_0000;
                g2 = 32'h8000_0000;
                dm = 1;
            end
            3: dm = 0;
            5: begin
                g0 = 32'($urandom_range(524287)) - 32'd262144;
                g1 = 32'($urandom_range(524287)) - 32'd262144;
                g2 = 32'($urandom_range(524287)) - 32'd262144;
            end
            default: ;
        endcase
        write_reg(qpps_pkg::REG_GAIN_NOW, g0);
        write_reg(qpps_pkg::REG_GAIN_PREV, g1);
        write_reg(qpps_pkg::REG_GAIN_PREV2, g2);
        write_reg(qpps_pkg::REG_DUTY_MAX, dm);
        send_idle = (p < 2) ? 26 : (p < 4) ? 74 : 0;
        recv_idle = (p < 2) ? 74 : (p < 4) ? 26 : 0;
    endtask

    initial begin
        send_idle = 26;
        recv_idle = 74;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick at reset defaults, zero gains give no drive
        send_item(qpps_pkg::ACT_TICK, 1'b0, 1'b0, 16'sd0);
        i_valid <= 1'b0;
        drain();
        write_reg(qpps_pkg::REG_GAIN_NOW, 32'hFFFC_0000);
        write_reg(qpps_pkg::REG_GAIN_PREV, 32'h0006_0000);
        write_reg(qpps_pkg::REG_GAIN_PREV2, 32'hFFFE_0000);
        write_reg(qpps_pkg::REG_DUTY_MAX, 32'd1023);

        // every level pair on both channels
        send_item(qpps_pkg::ACT_EDGE_A, 1'b0, 1'b0, 16'sd0);
        send_item(qpps_pkg::ACT_EDGE_A, 1'b1, 1'b0, 16'sh7FFF);
        send_item(qpps_pkg::ACT_EDGE_A, 1'b1, 1'b1, 16'sh8000);
        send_item(qpps_pkg::ACT_EDGE_A, 1'b0, 1'b1, -16'sd1);
        send_item(qpps_pkg::ACT_EDGE_B, 1'b0, 1'b0, 16'sh8000);
        send_item(qpps_pkg::ACT_EDGE_B, 1'b1, 1'b0, 16'sh7FFF);
        send_item(qpps_pkg::ACT_EDGE_B, 1'b1, 1'b1, 16'sd0);
        send_item(qpps_pkg::ACT_EDGE_B, 1'b0, 1'b1, -16'sd1);
        // extreme targets, levels set to show they are ignored
        send_item(qpps_pkg::ACT_TARGET, 1'b1, 1'b1, 16'sh7FFF);
        send_item(qpps_pkg::ACT_TICK, 1'b1, 1'b1, 16'sh8000);
        send_item(qpps_pkg::ACT_TICK, 1'b0, 1'b0, 16'sd0);
        send_item(qpps_pkg::ACT_TICK, 1'b1, 1'b0, 16'sh7FFF);
        send_item(qpps_pkg::ACT_TARGET, 1'b0, 1'b1, 16'sh8000);
        send_item(qpps_pkg::ACT_TICK, 1'b0, 1'b1, 16'sd0);
        send_item(qpps_pkg::ACT_TICK, 1'b1, 1'b1, 16'sh7FFF);
        send_item(qpps_pkg::ACT_TARGET, 1'b0, 1'b0, 16'sd0);
        send_item(qpps_pkg::ACT_TICK, 1'b0, 1'b0, 16'sd0);
        send_item(qpps_pkg::ACT_TARGET, 1'b1, 1'b0, 16'sd1);
        send_item(qpps_pkg::ACT_TICK, 1'b0, 1'b0, 16'sd0);
        send_item(qpps_pkg::ACT_TICK, 1'b0, 1'b0, 16'sd0);
        i_valid <= 1'b0;

        for (int p = 0; p < 6; p++) begin
            drain();
            set_phase(p);
            repeat (150) send_random_item();
            i_valid <= 1'b0;
        end

        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("quadrature_position_pid_servo_core test passed");
        end else begin
            $display("quadrature_position_pid_servo_core test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("quadrature_position_pid_servo_core test failed");
        $finish;
    end

endmodule
